// ===== hw/rtl/mft_pkg.sv =====
// Package for the Magic Formula tire force block: fixed point helpers,
// CORDIC constants, register indexes and shared types. No dependencies.
package mft_pkg;

  localparam int unsigned FRAC_BITS    = 16;
  localparam int unsigned CORDIC_ITERS = 30;
  localparam int unsigned NUM_REGS     = 8;
  localparam int unsigned ADDR_W       = 5;

  localparam logic [63:0]        Q30_TWO_PI   = 64'd6746518853;
  localparam logic signed [33:0] Q30_PI       = 34'sd3373259426;
  localparam logic signed [33:0] Q30_HALF_PI  = 34'sd1686629713;
  localparam logic signed [33:0] Q30_GAIN_INV = 34'sd652032874;

  localparam logic [2:0] ROAD_MIN = 3'd1;
  localparam logic [2:0] ROAD_MAX = 3'd4;

  localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

  typedef enum logic [2:0] {
    REG_LONG_B = 3'd0,
    REG_LONG_C = 3'd1,
    REG_LONG_D = 3'd2,
    REG_LONG_E = 3'd3,
    REG_LAT_B  = 3'd4,
    REG_LAT_C  = 3'd5,
    REG_LAT_D  = 3'd6,
    REG_LAT_E  = 3'd7
  } reg_idx_e;

  localparam logic [31:0] REG_RESET [NUM_REGS] = '{
    32'd196608, 32'd95027, 32'd1248913, 32'd34079,
    32'd655360, 32'd95027, 32'd89850, 32'd63570
  };

  typedef struct packed {
    logic signed [31:0] b;
    logic signed [31:0] c;
    logic signed [31:0] d;
    logic signed [31:0] e;
  } coef_t;

  // Sideband that travels with each word down the pipeline.
  typedef struct packed {
    logic mode;
    logic bad;
  } side_t;

  function automatic logic signed [31:0] atan_q30(int unsigned i);
    logic signed [31:0] t;
    case (i)
      0:  t = 32'sd843314857;
      1:  t = 32'sd497837829;
      2:  t = 32'sd263043837;
      3:  t = 32'sd133525159;
      4:  t = 32'sd67021687;
      5:  t = 32'sd33543516;
      6:  t = 32'sd16775851;
      7:  t = 32'sd8388437;
      8:  t = 32'sd4194283;
      9:  t = 32'sd2097149;
      default: t = 32'sd1 <<< (30 - i);
    endcase
    return t;
  endfunction

  function automatic logic signed [31:0] sat32(logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > SAT_MAX) r = 32'sh7fffffff;
    else if (v < SAT_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] fx_mul(logic signed [31:0] a,
                                                logic signed [31:0] b,
                                                int unsigned f);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    logic signed [63:0] p;
    ae = a;
    be = b;
    p  = ae * be;
    return sat32(p >>> f);
  endfunction

  function automatic logic signed [31:0] fx_sub(logic signed [31:0] a,
                                                logic signed [31:0] b);
    logic signed [63:0] ae;
    logic signed [63:0] be;
    ae = a;
    be = b;
    return sat32(ae - be);
  endfunction

  // Round a Q30 value to nearest, half up, into f fractional bits.
  function automatic logic signed [31:0] q30_to_fx(logic signed [63:0] v,
                                                   int unsigned f);
    logic signed [63:0] r;
    r = v + (64'sd1 <<< (29 - f));
    return sat32(r >>> (30 - f));
  endfunction

endpackage

// ===== hw/rtl/mft_regs.sv =====
// Coefficient register file with an APB-style write and read port.
// Depends on mft_pkg.
module mft_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mft_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output mft_pkg::coef_t              coef_o [2]
);

  logic [31:0] regs_q [mft_pkg::NUM_REGS];
  logic [2:0]  idx;

  assign idx    = paddr[mft_pkg::ADDR_W-1:2];
  assign pready = 1'b1;
  assign prdata = regs_q[idx];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= mft_pkg::REG_RESET;
    end else if (psel && penable && pwrite) begin
      regs_q[idx] <= pwdata;
    end
  end

  always_comb begin
    coef_o[0].b = regs_q[mft_pkg::REG_LONG_B];
    coef_o[0].c = regs_q[mft_pkg::REG_LONG_C];
    coef_o[0].d = regs_q[mft_pkg::REG_LONG_D];
    coef_o[0].e = regs_q[mft_pkg::REG_LONG_E];
    coef_o[1].b = regs_q[mft_pkg::REG_LAT_B];
    coef_o[1].c = regs_q[mft_pkg::REG_LAT_C];
    coef_o[1].d = regs_q[mft_pkg::REG_LAT_D];
    coef_o[1].e = regs_q[mft_pkg::REG_LAT_E];
  end

endmodule

// ===== hw/rtl/mft_atan.sv =====
// Pipelined vectoring CORDIC arctangent, one iteration per stage, with an
// auxiliary word and sideband carried alongside. Depends on mft_pkg.
module mft_atan #(
  parameter int unsigned FracBits = mft_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] t_i,
  input  logic        [31:0] aux_i,
  input  mft_pkg::side_t     side_i,
  output logic               valid_o,
  output logic signed [31:0] atan_o,
  output logic        [31:0] aux_o,
  output mft_pkg::side_t     side_o
);

  localparam int unsigned N  = mft_pkg::CORDIC_ITERS;
  localparam int unsigned CW = 64 - FracBits;

  logic                 v_q   [N+2];
  logic signed [CW-1:0] x_q   [N+1];
  logic signed [CW-1:0] y_q   [N+1];
  logic signed [31:0]   z_q   [N+1];
  logic        [31:0]   aux_q [N+2];
  mft_pkg::side_t       side_q[N+2];
  logic signed [31:0]   res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= CW'(64'sd1 <<< 30);
      y_q[0]    <= CW'($signed(t_i)) <<< (30 - FracBits);
      z_q[0]    <= '0;
      aux_q[0]  <= aux_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (y_q[i] > 0) begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] + mft_pkg::atan_q30(i);
        end else begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          z_q[i+1] <= z_q[i] - mft_pkg::atan_q30(i);
        end
        aux_q[i+1]  <= aux_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[N+1] <= 1'b0;
    end else if (en_i) begin
      v_q[N+1] <= v_q[N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q       <= mft_pkg::q30_to_fx(64'(z_q[N]), FracBits);
      aux_q[N+1]  <= aux_q[N];
      side_q[N+1] <= side_q[N];
    end
  end

  assign valid_o = v_q[N+1];
  assign atan_o  = res_q;
  assign aux_o   = aux_q[N+1];
  assign side_o  = side_q[N+1];

endmodule

// ===== hw/rtl/mft_sin.sv =====
// Pipelined sine: modulo 2*pi reduction by a chain of compare and subtract
// stages, quadrant fold, then a rotation CORDIC. Depends on mft_pkg.
module mft_sin #(
  parameter int unsigned FracBits = mft_pkg::FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [31:0] arg_i,
  input  mft_pkg::side_t     side_i,
  output logic               valid_o,
  output logic signed [31:0] sin_o,
  output mft_pkg::side_t     side_o
);

  localparam int unsigned N  = mft_pkg::CORDIC_ITERS;
  localparam int unsigned MW = 62 - FracBits;
  // Reduction steps so that 2*pi times 2**R exceeds the largest magnitude.
  localparam int unsigned R  = 29 - FracBits;
  // Stages: load, R reductions, sign and fold, N rotations, rounding.
  localparam int unsigned S  = R + N + 3;

  logic                 v_q    [S];
  mft_pkg::side_t       side_q [S];
  logic        [MW-1:0] m_q    [R+1];
  logic                 neg_q  [R+1];
  logic signed [33:0]   x_q    [N+1];
  logic signed [33:0]   y_q    [N+1];
  logic signed [33:0]   r_q    [N+1];
  logic signed [31:0]   res_q;
  logic signed [MW-1:0] v_scaled;
  logic signed [33:0]   r_red;
  logic signed [33:0]   r_fold;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  for (genvar s = 1; s < S; s++) begin : g_valid
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (en_i) begin
        v_q[s] <= v_q[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  assign v_scaled = MW'($signed(arg_i)) <<< (30 - FracBits);

  // The magnitude is reduced; the remainder takes the sign of the argument.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      neg_q[0]  <= v_scaled[MW-1];
      m_q[0]    <= v_scaled[MW-1] ? MW'(-v_scaled) : MW'(v_scaled);
    end
  end

  for (genvar j = 0; j < R; j++) begin : g_red
    localparam logic [63:0] KS = mft_pkg::Q30_TWO_PI << (R - 1 - j);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (64'(m_q[j]) >= KS) begin
          m_q[j+1] <= m_q[j] - KS[MW-1:0];
        end else begin
          m_q[j+1] <= m_q[j];
        end
        neg_q[j+1] <= neg_q[j];
      end
    end
  end

  always_comb begin
    r_red  = neg_q[R] ? -$signed({1'b0, m_q[R][32:0]}) : $signed({1'b0, m_q[R][32:0]});
    r_fold = r_red;
    if (r_fold > mft_pkg::Q30_PI) r_fold = r_fold - 34'(mft_pkg::Q30_TWO_PI);
    if (r_fold < -mft_pkg::Q30_PI) r_fold = r_fold + 34'(mft_pkg::Q30_TWO_PI);
    if (r_fold > mft_pkg::Q30_HALF_PI) r_fold = mft_pkg::Q30_PI - r_fold;
    if (r_fold < -mft_pkg::Q30_HALF_PI) r_fold = -mft_pkg::Q30_PI - r_fold;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0] <= mft_pkg::Q30_GAIN_INV;
      y_q[0] <= '0;
      r_q[0] <= r_fold;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_iter
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (r_q[i] >= 0) begin
          x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
          r_q[i+1] <= r_q[i] - 34'(mft_pkg::atan_q30(i));
        end else begin
          x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
          y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
          r_q[i+1] <= r_q[i] + 34'(mft_pkg::atan_q30(i));
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= mft_pkg::q30_to_fx(64'(y_q[N]), FracBits);
    end
  end

  assign valid_o = v_q[S-1];
  assign sin_o   = res_q;
  assign side_o  = side_q[S-1];

endmodule

// ===== hw/rtl/magic_formula_tire_force.sv =====
// Magic Formula tire force block, top level.
// Depends on mft_pkg, mft_regs, mft_atan and mft_sin.

// Takes one slip word per cycle while in_ready_o is high and returns F =
// D*sin(C*atan(B*s - E*(B*s - atan(B*s)))) with the B, C, D, E registers of
// the chosen direction. The pipeline is a single chain that advances whenever
// the output register is empty or being read; its depth is set by the two
// arctangent CORDICs, the sine argument reduction and the sine CORDIC, one
// iteration per stage. A road type outside 1..4 gives zero force with
// bad_road set. Coefficients are read live, so they must be written only
// while the block is idle; the user keeps to this, the block does not enforce it.
module magic_formula_tire_force #(
  parameter int unsigned FracBits = mft_pkg::FRAC_BITS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [mft_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [31:0]         slip_i,
  input  logic                       mode_i,
  input  logic [2:0]                 road_type_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic signed [31:0]         force_res_o,
  output logic                       bad_road_o
);

  mft_pkg::coef_t     coef [2];
  logic               en;

  logic               v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic signed [31:0] bs_q, inner_q, inner2_q, arg_q, force_q;
  logic        [31:0] bs2_q;
  mft_pkg::side_t     side1_q, side2_q, side3_q, side4_q;
  logic               bad_q;

  logic               a1_v, a2_v, s_v;
  logic signed [31:0] a1_res, a2_res, s_res;
  logic        [31:0] a1_aux, a2_aux;
  mft_pkg::side_t     a1_side, a2_side, s_side, in_side;

  mft_regs u_regs (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .coef_o(coef)
  );

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  assign in_side.mode = mode_i;
  assign in_side.bad  = (road_type_i < mft_pkg::ROAD_MIN) ||
                        (road_type_i > mft_pkg::ROAD_MAX);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= in_valid_i;
      v2_q    <= a1_v;
      v3_q    <= v2_q;
      v4_q    <= a2_v;
      out_v_q <= s_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      bs_q     <= mft_pkg::fx_mul(coef[mode_i].b, slip_i, FracBits);
      side1_q  <= in_side;
      inner_q  <= mft_pkg::fx_sub(a1_aux, a1_res);
      bs2_q    <= a1_aux;
      side2_q  <= a1_side;
      inner2_q <= mft_pkg::fx_sub(bs2_q,
                    mft_pkg::fx_mul(coef[side2_q.mode].e, inner_q, FracBits));
      side3_q  <= side2_q;
      arg_q    <= mft_pkg::fx_mul($signed(a2_aux), a2_res, FracBits);
      side4_q  <= a2_side;
      force_q  <= s_side.bad ? '0
                             : mft_pkg::fx_mul(coef[s_side.mode].d, s_res, FracBits);
      bad_q    <= s_side.bad;
    end
  end

  mft_atan #(.FracBits(FracBits)) u_atan_bs (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v1_q), .t_i(bs_q), .aux_i(bs_q),
    .side_i(side1_q), .valid_o(a1_v), .atan_o(a1_res), .aux_o(a1_aux),
    .side_o(a1_side)
  );

  // The shape factor of each word travels beside it through the second arctangent.
  mft_atan #(.FracBits(FracBits)) u_atan_inner (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v3_q), .t_i(inner2_q),
    .aux_i(coef[side3_q.mode].c),
    .side_i(side3_q), .valid_o(a2_v), .atan_o(a2_res), .aux_o(a2_aux),
    .side_o(a2_side)
  );

  mft_sin #(.FracBits(FracBits)) u_sin (
    .clk_i, .rst_ni, .en_i(en), .valid_i(v4_q), .arg_i(arg_q), .side_i(side4_q),
    .valid_o(s_v), .sin_o(s_res), .side_o(s_side)
  );

  assign out_valid_o = out_v_q;
  assign force_res_o = force_q;
  assign bad_road_o  = bad_q;

endmodule
